// ===== sv/frame_rate_meter_limiter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame rate meter and limiter
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_METER_LIMITER_CORE_ASSERT_SVH
`define FRAME_RATE_METER_LIMITER_CORE_ASSERT_SVH

// Property checked outside reset.
`define FRML_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also covers the reset cycles.
`define FRML_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/frml_pkg.sv =====
// ----------------------------------------------------------------------------
// frml_pkg
// Types and constants shared by the frame rate meter and limiter.
// ----------------------------------------------------------------------------
package frml_pkg;

  localparam int SAMPLES_DEF = 10;

  localparam int FPS_W    = 22;
  localparam int FPS_RATE = 256000;   // 1000 frames per second in Q.8
  localparam logic [FPS_W-1:0] FPS_MAX_Q8     = 22'h3FFFFF;
  localparam logic [FPS_W-1:0] FPS_DEFAULT_Q8 = 22'd15360;

  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] MAX_FPS_RESET = 10'd60;
  localparam logic [CFG_W-1:0] BUDGET_NUM    = 10'd1000;

  localparam int TS_W     = 32;
  localparam int PERIOD_W = 16;
  localparam int DELAY_W  = 10;

  typedef struct packed {
    logic [TS_W-1:0] frame_start_ms;
    logic [TS_W-1:0] frame_end_ms;
  } in_word_t;

  typedef struct packed {
    logic [FPS_W-1:0]    fps_q8;
    logic                fps_fresh;
    logic [DELAY_W-1:0]  delay_ms;
    logic [PERIOD_W-1:0] frame_period_ms;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== sv/frml_ram.sv =====
// ----------------------------------------------------------------------------
// frml_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/frml_div.sv =====
// ----------------------------------------------------------------------------
// frml_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frml_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvsr;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, q[NUM_W-1]};
    trial   = shifted - {1'b0, dvsr};
    fits    = !trial[DEN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= num;
      rem  <= '0;
      dvsr <= den;
    end else if (busy) begin
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], fits};
    end
  end

  assign quot = q;

endmodule

// ===== sv/frame_rate_meter_limiter_core.sv =====
// Path: the accepting edge moves to ST_READ, the divides run in ST_DIV, and ST_DONE loads
// the result word; the bit-serial rate divider sets how long ST_DIV lasts.
// Words are taken one at a time: a new word waits until the previous one reaches the output
// register, and ST_DONE holds while a full output register stays stalled; a new word is taken
// while the previous result still waits in the output register.
// Reset (rst, synchronous): ring empty, sum zero, rate 60.0, ceiling 60 fps.
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter_core
// Averages frame periods over a ring of SAMPLES entries, reports the frame
// rate in Q.8 and the delay needed to respect a frame-rate ceiling.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter_core #(
  parameter int SAMPLES = frml_pkg::SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [frml_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  frml_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output frml_pkg::out_word_t           out_word
);

  // Ring geometry and arithmetic widths, all derived from SAMPLES.
  localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int SUM_W  = $clog2(SAMPLES * 65535 + 1);
  localparam int FNUM   = SAMPLES * frml_pkg::FPS_RATE;
  localparam int FNUM_W = $clog2(FNUM + 1);
  localparam int QW     = (FNUM_W > frml_pkg::FPS_W) ? FNUM_W : frml_pkg::FPS_W;
  localparam int TS_W   = frml_pkg::TS_W;
  localparam int PER_W  = frml_pkg::PERIOD_W;
  localparam int CFG_W  = frml_pkg::CFG_W;

  frml_pkg::state_t state, state_next;

  // Configuration.
  logic [CFG_W-1:0] max_fps;

  // Meter state.
  logic [TS_W-1:0]   last_end;
  logic              seen_first;
  logic [SLOT_W-1:0] ring_slot;
  logic [CNT_W-1:0]  frames_counted;
  logic [SUM_W-1:0]  period_sum;
  logic [frml_pkg::FPS_W-1:0] held_fps;

  // Per-word working registers.
  logic [PER_W-1:0] period;
  logic [TS_W-1:0]  elapsed;
  logic             fresh;

  // Delay staged at the end of the divides, and the output register flag.
  logic [frml_pkg::DELAY_W-1:0] delay_reg;
  logic                         out_full;

  // Handshake decodes from the state machine.
  logic in_take;
  logic do_update;
  logic div_done;
  logic out_load;

  // Combinational helpers.
  logic [TS_W-1:0]   end_diff;
  logic [PER_W-1:0]  period_in;
  logic [PER_W-1:0]  old_period;
  logic [PER_W-1:0]  ring_rdata;
  logic [SUM_W-1:0]  sum_next;
  logic              warm;
  logic [CFG_W-1:0]  ceil_fps;
  logic              fps_busy;
  logic              bud_busy;
  logic [FNUM_W-1:0] fps_quot;
  logic [CFG_W-1:0]  budget;
  logic [QW-1:0]     fps_ext;
  logic [frml_pkg::FPS_W-1:0] fps_sat;
  logic [frml_pkg::DELAY_W-1:0] delay;

  // --------------------------------------------------------------------------
  // Sequencer: take a word, read the retiring ring entry, run both divides,
  // then hand the result to the output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    in_take    = 1'b0;
    do_update  = 1'b0;
    div_done   = 1'b0;
    out_load   = 1'b0;
    case (state)
      frml_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          in_take    = 1'b1;
          state_next = frml_pkg::ST_READ;
        end
      end
      frml_pkg::ST_READ: begin
        // Ring read data is valid now; update sum and start the divides.
        do_update  = 1'b1;
        state_next = frml_pkg::ST_DIV;
      end
      frml_pkg::ST_DIV: begin
        if (!fps_busy && !bud_busy) begin
          div_done   = 1'b1;
          state_next = frml_pkg::ST_DONE;
        end
      end
      frml_pkg::ST_DONE: begin
        // Hold until the output register is free or being drained.
        if (!out_full || !out_stall) begin
          out_load   = 1'b1;
          state_next = frml_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = frml_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Period of the incoming word: end-to-end against the previous end,
  // saturated to 16 bits, zero on the very first frame.
  // --------------------------------------------------------------------------
  always_comb begin
    end_diff = in_word.frame_end_ms - last_end;
    if (!seen_first) begin
      period_in = '0;
    end else if (end_diff[TS_W-1:PER_W] != '0) begin
      period_in = '1;
    end else begin
      period_in = end_diff[PER_W-1:0];
    end
  end

  // Entries not yet written during warm-up read as zero.
  assign warm       = (frames_counted < CNT_W'(SAMPLES));
  assign old_period = warm ? '0 : ring_rdata;
  assign sum_next   = period_sum - SUM_W'(old_period) + SUM_W'(period);

  // A ceiling of zero counts as one.
  assign ceil_fps = (max_fps == '0) ? CFG_W'(1) : max_fps;

  frml_ram #(
    .WIDTH (PER_W),
    .DEPTH (SAMPLES)
  ) u_ring (
    .clk   (clk),
    .we    (do_update),
    .waddr (ring_slot),
    .wdata (period),
    .raddr (ring_slot),
    .rdata (ring_rdata)
  );

  // Rate divide: SAMPLES*1000 in Q.8 over the updated period sum.
  frml_div #(
    .NUM_W (FNUM_W),
    .DEN_W (SUM_W)
  ) u_fps_div (
    .clk   (clk),
    .rst   (rst),
    .start (do_update),
    .num   (FNUM_W'(FNUM)),
    .den   (sum_next),
    .busy  (fps_busy),
    .quot  (fps_quot)
  );

  // Frame budget: whole milliseconds per frame at the ceiling.
  frml_div #(
    .NUM_W (CFG_W),
    .DEN_W (CFG_W)
  ) u_bud_div (
    .clk   (clk),
    .rst   (rst),
    .start (do_update),
    .num   (frml_pkg::BUDGET_NUM),
    .den   (ceil_fps),
    .busy  (bud_busy),
    .quot  (budget)
  );

  // Saturate the rate to the field width.
  always_comb begin
    fps_ext = QW'(fps_quot);
    if (fps_ext > QW'(frml_pkg::FPS_MAX_Q8)) begin
      fps_sat = frml_pkg::FPS_MAX_Q8;
    end else begin
      fps_sat = fps_ext[frml_pkg::FPS_W-1:0];
    end
  end

  // Wait only for what is left of the budget after the frame's own time.
  assign delay = (TS_W'(budget) > elapsed) ?
                 frml_pkg::DELAY_W'(TS_W'(budget) - elapsed) : '0;

  // --------------------------------------------------------------------------
  // Control state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fps        <= frml_pkg::MAX_FPS_RESET;
      last_end       <= '0;
      seen_first     <= 1'b0;
      ring_slot      <= '0;
      frames_counted <= '0;
      period_sum     <= '0;
      held_fps       <= frml_pkg::FPS_DEFAULT_Q8;
      out_full       <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_fps <= cfg_wdata;
      end
      if (in_take) begin
        last_end   <= in_word.frame_end_ms;
        seen_first <= 1'b1;
      end
      if (do_update) begin
        period_sum <= sum_next;
        // Advance the slot, wrap at SAMPLES.
        if (ring_slot == SLOT_W'(SAMPLES - 1)) begin
          ring_slot <= '0;
        end else begin
          ring_slot <= ring_slot + 1'b1;
        end
        if (warm) begin
          frames_counted <= frames_counted + 1'b1;
        end
      end
      if (div_done && fresh) begin
        held_fps <= (period_sum == '0) ? frml_pkg::FPS_DEFAULT_Q8 : fps_sat;
      end
      if (out_load) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      period  <= period_in;
      elapsed <= in_word.frame_end_ms - in_word.frame_start_ms;
    end
    if (do_update) begin
      fresh <= !warm;
    end
    if (div_done) begin
      delay_reg <= delay;
    end
    if (out_load) begin
      out_word.fps_q8          <= held_fps;
      out_word.fps_fresh       <= fresh;
      out_word.delay_ms        <= delay_reg;
      out_word.frame_period_ms <= period;
    end
  end

  assign out_valid = out_full;

endmodule

// ===== sv/frml_checker.sv =====
// ----------------------------------------------------------------------------
// frml_checker
// Port-level checks for the frame rate meter and limiter.
// ----------------------------------------------------------------------------
`include "frame_rate_meter_limiter_core_assert.svh"

module frml_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input frml_pkg::out_word_t out_word
);

  // A stalled result word stays up and unchanged.
  `FRML_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled result word dropped or changed")

  // One word at a time: after a take, the input side stalls.
  `FRML_ASSERT(a_in_busy, clk, rst, in_valid && !in_stall |=> in_stall, "input taken while a word is in work")

  // Delay never exceeds one second.
  `FRML_ASSERT(a_delay_range, clk, rst, out_valid |-> out_word.delay_ms <= 10'd1000, "delay out of range")

  // Reset empties the output register.
  `FRML_ASSERT_RST(a_rst_empty, clk, rst |=> !out_valid, "result word present after reset")

endmodule

bind frame_rate_meter_limiter_core frml_checker u_frml_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
